[rtl/lzsu_pkg.sv]
package lzsu_pkg;

    // History ring; the depth is a power of two between 256 and 65536
    localparam int HISTORY_DEPTH = 65536;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);

    // Byte codes of the compressed stream
    localparam logic [7:0] BYTE_ESC       = 8'h80;
    localparam logic [7:0] BYTE_TOK_FIRST = 8'h83;
    localparam logic [7:0] BYTE_TOK_END   = 8'hC0;

    localparam int SIZE_W = 6;
    localparam int OFFS_W = 16;

    // History write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } hist_wr_t;

endpackage

[rtl/lz_string_unstuffer_unit.sv]
// Channel | Dir | tdata             | tuser                      | tlast
// s_      | in  | [7:0] comp_byte   | -                          | -
// m_      | out | [7:0] out_byte    | [0] string_end [1] bad_offset | run_last
//
// A byte that gives no result or one result is handled when it is accepted, except a
// bad offset low byte, which is accepted and then stored in STORE. A good offset
// low byte is accepted, then each copied byte passes through READ and EMIT, then
// the byte is stored in STORE; this order is set by the single history read port
// and its registered read data.
// Reset (aresetn low, synchronous) clears the pointer, the parse phase and the
// sequencer; the history ring holds no reset value.
// A stalled result register holds the sequencer in EMIT and blocks new input.
module lz_string_unstuffer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] comp_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] string_end, [1] bad_offset
    output logic       m_tlast    // run_last
);
    import lzsu_pkg::*;

    typedef enum logic [3:0] {
        PH_NORMAL = 4'b0001,
        PH_ESCAPE = 4'b0010,
        PH_OFS_HI = 4'b0100,
        PH_OFS_LO = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        SEQ_IDLE  = 4'b0001,
        SEQ_READ  = 4'b0010,
        SEQ_EMIT  = 4'b0100,
        SEQ_STORE = 4'b1000
    } seq_t;

    phase_t            phase_reg, phase_next;
    seq_t              seq_reg, seq_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] tok_pos_reg, tok_pos_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [SIZE_W-1:0] copy_size_reg, copy_size_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        offs_hi_reg, offs_hi_next;
    logic [7:0]        low_byte_reg, low_byte_next;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;
    logic              m_last_reg, m_last_next;

    logic              accept;
    logic              out_free;
    logic [OFFS_W-1:0] offs;
    logic              offs_bad;
    hist_wr_t          hist_wr;
    logic [7:0]        rd_data;

    lzsu_history u_history (
        .aclk    (aclk),
        .wr      (hist_wr),
        .rd_addr (src_reg),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (seq_reg == SEQ_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign offs     = {offs_hi_reg, s_tdata};
    assign offs_bad = (offs == '0) || (offs < OFFS_W'(copy_size_reg));

    // Parse and sequence
    always_comb begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        wp_next        = wp_reg;
        tok_pos_next   = tok_pos_reg;
        src_next       = src_reg;
        copy_size_next = copy_size_reg;
        cnt_next       = cnt_reg;
        offs_hi_next   = offs_hi_reg;
        low_byte_next  = low_byte_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;
        hist_wr.en     = 1'b0;
        hist_wr.addr   = wp_reg;
        hist_wr.data   = s_tdata;

        case (seq_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    // Store every byte now, but the offset low byte later, in STORE
                    if (phase_reg != PH_OFS_LO) begin
                        hist_wr.en = 1'b1;
                        wp_next    = wp_reg + 1'b1;
                    end
                    case (phase_reg)
                        PH_ESCAPE: begin
                            m_valid_next = 1'b1;
                            m_data_next  = s_tdata;
                            m_user_next  = 2'b00;
                            m_last_next  = 1'b1;
                            phase_next   = PH_NORMAL;
                        end
                        PH_OFS_HI: begin
                            offs_hi_next = s_tdata;
                            phase_next   = PH_OFS_LO;
                        end
                        PH_OFS_LO: begin
                            low_byte_next = s_tdata;
                            phase_next    = PH_NORMAL;
                            if (offs_bad) begin
                                m_valid_next = 1'b1;
                                m_data_next  = 8'h00;
                                m_user_next  = 2'b10;
                                m_last_next  = 1'b1;
                                seq_next     = SEQ_STORE;
                            end else begin
                                src_next = tok_pos_reg - offs[ADDR_W-1:0];
                                cnt_next = copy_size_reg;
                                seq_next = SEQ_READ;
                            end
                        end
                        default: begin
                            if (s_tdata == BYTE_ESC) begin
                                phase_next = PH_ESCAPE;
                            end else if (s_tdata inside
                                         {[BYTE_TOK_FIRST:BYTE_TOK_END - 8'd1]}) begin
                                copy_size_next = SIZE_W'(s_tdata - BYTE_ESC);
                                tok_pos_next   = wp_reg;
                                phase_next     = PH_OFS_HI;
                            end else begin
                                m_valid_next = 1'b1;
                                m_data_next  = s_tdata;
                                m_user_next  = {1'b0, s_tdata == 8'h00};
                                m_last_next  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            SEQ_READ: begin
                // Read address is src_reg; data lands next cycle
                seq_next = SEQ_EMIT;
            end
            SEQ_EMIT: begin
                // Hand one history byte to the result register, then advance
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_data;
                    m_user_next  = 2'b00;
                    m_last_next  = (cnt_reg == SIZE_W'(1));
                    src_next     = src_reg + 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    seq_next     = (cnt_reg == SIZE_W'(1)) ? SEQ_STORE : SEQ_READ;
                end
            end
            SEQ_STORE: begin
                // Store the held offset low byte
                hist_wr.en   = 1'b1;
                hist_wr.data = low_byte_reg;
                wp_next      = wp_reg + 1'b1;
                seq_next     = SEQ_IDLE;
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NORMAL;
            seq_reg       <= SEQ_IDLE;
            wp_reg        <= '0;
            tok_pos_reg   <= '0;
            copy_size_reg <= '0;
            offs_hi_reg   <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            wp_reg        <= wp_next;
            tok_pos_reg   <= tok_pos_next;
            copy_size_reg <= copy_size_next;
            offs_hi_reg   <= offs_hi_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        src_reg      <= src_next;
        low_byte_reg <= low_byte_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'h00))
        else $error("bad offset result is not a lone zero result");

    a_end_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'h00) && !m_tuser[1])
        else $error("string end result malformed");

    a_store_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SEQ_STORE |=> seq_reg == SEQ_IDLE
                                 && wp_reg == $past(wp_reg) + ADDR_W'(1))
        else $error("deferred store did not advance the pointer");

    a_read_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SEQ_READ |-> cnt_reg != '0 && !s_tready)
        else $error("copy read with no bytes left");

endmodule

[rtl/lzsu_history.sv]
module lzsu_history (
    input  logic                      aclk,
    input  lzsu_pkg::hist_wr_t        wr,
    input  logic [lzsu_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import lzsu_pkg::*;

    logic [7:0] mem [HISTORY_DEPTH];
    logic [7:0] rd_data_reg;

    // Write one byte, read one byte, read data registered
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
